// ===== sv/psq_pkg.sv =====
// Shared constants, types and helpers for the presence sensor qualifier.
// No dependencies; used by presence_sensor_qualifier.
`default_nettype none

package psq_pkg;

  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Qualifier phase codes
  typedef logic [2:0] phase_t;
  localparam phase_t PH_INIT  = 3'd0;
  localparam phase_t PH_IDLE  = 3'd1;
  localparam phase_t PH_ENTER = 3'd2;
  localparam phase_t PH_HERE  = 3'd3;
  localparam phase_t PH_EXIT  = 3'd4;

  // Configuration register indexes
  localparam cfg_idx_t REG_TRIGGER    = 3'd0;
  localparam cfg_idx_t REG_ERROR      = 3'd1;
  localparam cfg_idx_t REG_ENTER_WIN  = 3'd2;
  localparam cfg_idx_t REG_EXIT_WIN   = 3'd3;
  localparam cfg_idx_t REG_STAY_SHORT = 3'd4;
  localparam cfg_idx_t REG_STAY_LONG  = 3'd5;
  localparam cfg_idx_t REG_ABSENT     = 3'd6;

  // Register reset values
  localparam cnt_t RST_TRIGGER    = 16'd50;
  localparam cnt_t RST_ERROR      = 16'd20;
  localparam cnt_t RST_ENTER_WIN  = 16'd300;
  localparam cnt_t RST_EXIT_WIN   = 16'd500;
  localparam cnt_t RST_STAY_SHORT = 16'd500;
  localparam cnt_t RST_STAY_LONG  = 16'd6000;
  localparam cnt_t RST_ABSENT     = 16'd500;

  localparam cnt_t CNT_MAX = '1;

  // Saturating increment
  function automatic cnt_t inc_sat(input cnt_t v);
    return (v == CNT_MAX) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  // Saturating sum compared against a limit; the 17-bit sum gives the same
  // answer as the clamped one since the limit never exceeds the clamp value
  function automatic logic sum_reaches(input cnt_t a, input cnt_t b, input cnt_t lim);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s >= {1'b0, lim};
  endfunction

endpackage

`default_nettype wire

// ===== sv/presence_sensor_qualifier.sv =====
// Presence sensor qualifier: phase qualifier, stay/absence timers, edge pulses.
// Depends on psq_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, sensor_level) carries one sensor sample
//   per beat; a low level means a person is sensed. Each accepted beat yields
//   exactly one result beat on the output channel (out_valid/out_ready) with
//   present, leaving, stay_short, stay_long, absent_held, enter_pulse and
//   exit_pulse.
//   The result of a beat accepted at one edge is valid after that edge.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   whole update is saturating increments, 17-bit adds and compares in
//   front of the state registers.
//   The result register is refilled in the cycle it is taken, so in_ready is
//   high whenever the result slot is empty or being drained. While the
//   receiver stalls, in_ready drops and the result and all state hold.
//   Reset clears state and flags and loads the register defaults
//   (trigger 50, error 20, enter window 300, exit window 500, short stay
//   500, long stay 6000, absent hold 500). Writes through cfg_wr_en take
//   effect at the next edge; index 7 is ignored.
`default_nettype none

module presence_sensor_qualifier (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire psq_pkg::cfg_idx_t      cfg_index,
  input  wire psq_pkg::cnt_t          cfg_data,
  // sample channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   sensor_level,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        present,
  output logic                        leaving,
  output logic                        stay_short,
  output logic                        stay_long,
  output logic                        absent_held,
  output logic                        enter_pulse,
  output logic                        exit_pulse
);

  // Configuration registers
  psq_pkg::cnt_t trigger_count, error_count, enter_window, exit_window;
  psq_pkg::cnt_t stay_short_ticks, stay_long_ticks, absent_hold_ticks;

  // Qualifier and timer state
  psq_pkg::phase_t phase, phase_next;
  psq_pkg::cnt_t   active_run, active_run_next;
  psq_pkg::cnt_t   idle_run, idle_run_next;
  psq_pkg::cnt_t   stay_ticks, stay_ticks_next;
  psq_pkg::cnt_t   gone_ticks, gone_ticks_next;
  logic present_flag, present_flag_next;
  logic leaving_flag, leaving_flag_next;
  logic short_flag, short_flag_next;
  logic long_flag, long_flag_next;
  logic held_flag, held_flag_next;
  logic enter_pulse_next, exit_pulse_next;

  logic accept;
  logic sensed;
  psq_pkg::cnt_t stay_inc, gone_inc, active_inc, idle_inc;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign sensed   = !sensor_level;

  assign stay_inc   = psq_pkg::inc_sat(stay_ticks);
  assign gone_inc   = psq_pkg::inc_sat(gone_ticks);
  assign active_inc = psq_pkg::inc_sat(active_run);
  assign idle_inc   = psq_pkg::inc_sat(idle_run);

  // Timing stage: works on the previous beat's present/leaving flags
  always_comb begin
    stay_ticks_next = stay_ticks;
    gone_ticks_next = gone_ticks;
    short_flag_next = short_flag;
    long_flag_next  = long_flag;
    held_flag_next  = held_flag;
    if (present_flag) begin
      held_flag_next  = 1'b0;
      gone_ticks_next = '0;
      if (!leaving_flag) begin
        stay_ticks_next = stay_inc;
        if (stay_inc >= stay_long_ticks) begin
          stay_ticks_next = stay_long_ticks;
          long_flag_next  = 1'b1;
        end else if (stay_inc >= stay_short_ticks) begin
          short_flag_next = 1'b1;
        end
      end else if (!short_flag) begin
        stay_ticks_next = '0;
      end
    end else begin
      stay_ticks_next = '0;
      short_flag_next = 1'b0;
      long_flag_next  = 1'b0;
      gone_ticks_next = gone_inc;
      if (gone_inc >= absent_hold_ticks) begin
        gone_ticks_next = absent_hold_ticks;
        held_flag_next  = 1'b1;
      end
    end
  end

  // Phase qualifier
  always_comb begin
    phase_next        = phase;
    active_run_next   = active_run;
    idle_run_next     = idle_run;
    present_flag_next = present_flag;
    leaving_flag_next = leaving_flag;
    case (phase)
      psq_pkg::PH_INIT: begin
        present_flag_next = 1'b0;
        leaving_flag_next = 1'b0;
        phase_next        = psq_pkg::PH_IDLE;
      end
      psq_pkg::PH_IDLE: begin
        present_flag_next = 1'b0;
        leaving_flag_next = 1'b0;
        if (sensed) begin
          active_run_next = active_inc;
          if (active_inc >= trigger_count) begin
            active_run_next = '0;
            idle_run_next   = '0;
            phase_next      = psq_pkg::PH_ENTER;
          end
        end else begin
          active_run_next = '0;
        end
      end
      psq_pkg::PH_ENTER: begin
        present_flag_next = 1'b0;
        leaving_flag_next = 1'b0;
        if (sensed) begin
          active_run_next = active_inc;
          if (psq_pkg::sum_reaches(active_inc, idle_run, enter_window))
            phase_next = psq_pkg::PH_HERE;
        end else if (idle_inc >= error_count) begin
          active_run_next = '0;
          idle_run_next   = '0;
          phase_next      = psq_pkg::PH_IDLE;
        end else begin
          idle_run_next = idle_inc;
          if (psq_pkg::sum_reaches(active_run, idle_inc, enter_window))
            phase_next = psq_pkg::PH_HERE;
        end
      end
      psq_pkg::PH_HERE: begin
        present_flag_next = 1'b1;
        leaving_flag_next = 1'b0;
        if (!sensed) begin
          idle_run_next = idle_inc;
          if (idle_inc >= trigger_count) begin
            active_run_next = '0;
            idle_run_next   = '0;
            phase_next      = psq_pkg::PH_EXIT;
          end
        end else begin
          idle_run_next = '0;
        end
      end
      psq_pkg::PH_EXIT: begin
        present_flag_next = 1'b1;
        leaving_flag_next = 1'b1;
        if (!sensed) begin
          idle_run_next = idle_inc;
          if (psq_pkg::sum_reaches(active_run, idle_inc, exit_window))
            phase_next = psq_pkg::PH_IDLE;
        end else if (active_inc >= error_count) begin
          active_run_next = '0;
          idle_run_next   = '0;
          phase_next      = psq_pkg::PH_HERE;
        end else begin
          active_run_next = active_inc;
          if (psq_pkg::sum_reaches(active_inc, idle_run, exit_window))
            phase_next = psq_pkg::PH_IDLE;
        end
      end
      default: begin
        // unreachable codes fall back to the initial phase
        phase_next        = psq_pkg::PH_INIT;
        leaving_flag_next = 1'b0;
      end
    endcase
  end

  // Edge stage: present_flag always equals the last reported presence
  assign enter_pulse_next = present_flag_next && !present_flag;
  assign exit_pulse_next  = !present_flag_next && present_flag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_count     <= psq_pkg::RST_TRIGGER;
      error_count       <= psq_pkg::RST_ERROR;
      enter_window      <= psq_pkg::RST_ENTER_WIN;
      exit_window       <= psq_pkg::RST_EXIT_WIN;
      stay_short_ticks  <= psq_pkg::RST_STAY_SHORT;
      stay_long_ticks   <= psq_pkg::RST_STAY_LONG;
      absent_hold_ticks <= psq_pkg::RST_ABSENT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psq_pkg::REG_TRIGGER:    trigger_count     <= cfg_data;
        psq_pkg::REG_ERROR:      error_count       <= cfg_data;
        psq_pkg::REG_ENTER_WIN:  enter_window      <= cfg_data;
        psq_pkg::REG_EXIT_WIN:   exit_window       <= cfg_data;
        psq_pkg::REG_STAY_SHORT: stay_short_ticks  <= cfg_data;
        psq_pkg::REG_STAY_LONG:  stay_long_ticks   <= cfg_data;
        psq_pkg::REG_ABSENT:     absent_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // State and result registers, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= psq_pkg::PH_INIT;
      active_run   <= '0;
      idle_run     <= '0;
      stay_ticks   <= '0;
      gone_ticks   <= '0;
      present_flag <= 1'b0;
      leaving_flag <= 1'b0;
      short_flag   <= 1'b0;
      long_flag    <= 1'b0;
      held_flag    <= 1'b0;
      enter_pulse  <= 1'b0;
      exit_pulse   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        active_run   <= active_run_next;
        idle_run     <= idle_run_next;
        stay_ticks   <= stay_ticks_next;
        gone_ticks   <= gone_ticks_next;
        present_flag <= present_flag_next;
        leaving_flag <= leaving_flag_next;
        short_flag   <= short_flag_next;
        long_flag    <= long_flag_next;
        held_flag    <= held_flag_next;
        enter_pulse  <= enter_pulse_next;
        exit_pulse   <= exit_pulse_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Flags only change on an accepted beat, which needs a free result slot
  assign present     = present_flag;
  assign leaving     = leaving_flag;
  assign stay_short  = short_flag;
  assign stay_long   = long_flag;
  assign absent_held = held_flag;

  // Checks
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(enter_pulse && exit_pulse))
    else $error("enter and exit pulse in the same beat");

  a_enter_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && enter_pulse) |-> present)
    else $error("enter pulse without presence");

  a_exit_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exit_pulse) |-> !present)
    else $error("exit pulse while present");

  a_leave_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && leaving) |-> present)
    else $error("exit window open without presence");

  a_held_short: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(absent_held && stay_short))
    else $error("absence hold and short stay both set");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for presence_sensor_qualifier: sample stimulus, result checks.
// Depends on psq_pkg and the presence_sensor_qualifier RTL only.

module testbench;

  // One result beat, field by field
  typedef struct packed {
    logic present;
    logic leaving;
    logic stay_short;
    logic stay_long;
    logic absent_held;
    logic enter_pulse;
    logic exit_pulse;
  } tick_flags_t;

  // Tracks occupancy the way the block should and holds the flags still owed
  class presence_tracker;
    psq_pkg::cnt_t trig_lim, err_lim, enter_win, exit_win, short_lim, long_lim, hold_lim;
    psq_pkg::phase_t ph;
    psq_pkg::cnt_t act_run, quiet_run, stay_cnt, gone_cnt;
    logic here, going, short_f, long_f, held_f, was_here;
    tick_flags_t due_flags[$];
    int errors;
    int checked;

    function new();
      trig_lim  = psq_pkg::RST_TRIGGER;
      err_lim   = psq_pkg::RST_ERROR;
      enter_win = psq_pkg::RST_ENTER_WIN;
      exit_win  = psq_pkg::RST_EXIT_WIN;
      short_lim = psq_pkg::RST_STAY_SHORT;
      long_lim  = psq_pkg::RST_STAY_LONG;
      hold_lim  = psq_pkg::RST_ABSENT;
      ph = psq_pkg::PH_INIT;
      act_run = '0;
      quiet_run = '0;
      stay_cnt = '0;
      gone_cnt = '0;
      here = 1'b0;
      going = 1'b0;
      short_f = 1'b0;
      long_f = 1'b0;
      held_f = 1'b0;
      was_here = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function psq_pkg::cnt_t bump(psq_pkg::cnt_t v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // clamped 16-bit sum of both run counters
    function psq_pkg::cnt_t run_total();
      logic [16:0] s;
      s = {1'b0, act_run} + {1'b0, quiet_run};
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void set_reg(psq_pkg::cfg_idx_t idx, psq_pkg::cnt_t val);
      case (idx)
        psq_pkg::REG_TRIGGER:    trig_lim = val;
        psq_pkg::REG_ERROR:      err_lim = val;
        psq_pkg::REG_ENTER_WIN:  enter_win = val;
        psq_pkg::REG_EXIT_WIN:   exit_win = val;
        psq_pkg::REG_STAY_SHORT: short_lim = val;
        psq_pkg::REG_STAY_LONG:  long_lim = val;
        psq_pkg::REG_ABSENT:     hold_lim = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_flags.size();
    endfunction

    // Advance one tick and queue the flags it should produce
    function void take_sample(logic level);
      logic sensed;
      tick_flags_t f;
      sensed = !level;

      // stay / absence timers run on last tick's presence and leaving
      if (here) begin
        held_f = 1'b0;
        gone_cnt = '0;
        if (!going) begin
          stay_cnt = bump(stay_cnt);
          if (stay_cnt >= long_lim) begin
            stay_cnt = long_lim;
            long_f = 1'b1;
          end else if (stay_cnt >= short_lim) begin
            short_f = 1'b1;
          end
        end else if (!short_f) begin
          stay_cnt = '0;
        end
      end else begin
        stay_cnt = '0;
        short_f = 1'b0;
        long_f = 1'b0;
        gone_cnt = bump(gone_cnt);
        if (gone_cnt >= hold_lim) begin
          gone_cnt = hold_lim;
          held_f = 1'b1;
        end
      end

      // phase qualifier
      case (ph)
        psq_pkg::PH_INIT: begin
          here = 1'b0;
          going = 1'b0;
          ph = psq_pkg::PH_IDLE;
        end
        psq_pkg::PH_IDLE: begin
          here = 1'b0;
          going = 1'b0;
          if (sensed) begin
            act_run = bump(act_run);
            if (act_run >= trig_lim) begin
              act_run = '0;
              quiet_run = '0;
              ph = psq_pkg::PH_ENTER;
            end
          end else begin
            act_run = '0;
          end
        end
        psq_pkg::PH_ENTER: begin
          here = 1'b0;
          going = 1'b0;
          if (sensed) act_run = bump(act_run);
          else quiet_run = bump(quiet_run);
          if (!sensed && quiet_run >= err_lim) begin
            act_run = '0;
            quiet_run = '0;
            ph = psq_pkg::PH_IDLE;
          end else if (run_total() >= enter_win) begin
            ph = psq_pkg::PH_HERE;
          end
        end
        psq_pkg::PH_HERE: begin
          here = 1'b1;
          going = 1'b0;
          if (!sensed) begin
            quiet_run = bump(quiet_run);
            if (quiet_run >= trig_lim) begin
              act_run = '0;
              quiet_run = '0;
              ph = psq_pkg::PH_EXIT;
            end
          end else begin
            quiet_run = '0;
          end
        end
        psq_pkg::PH_EXIT: begin
          here = 1'b1;
          going = 1'b1;
          if (sensed) act_run = bump(act_run);
          else quiet_run = bump(quiet_run);
          if (sensed && act_run >= err_lim) begin
            act_run = '0;
            quiet_run = '0;
            ph = psq_pkg::PH_HERE;
          end else if (run_total() >= exit_win) begin
            ph = psq_pkg::PH_IDLE;
          end
        end
        default: begin
          ph = psq_pkg::PH_INIT;
          going = 1'b0;
        end
      endcase

      f.present     = here;
      f.leaving     = going;
      f.stay_short  = short_f;
      f.stay_long   = long_f;
      f.absent_held = held_f;
      f.enter_pulse = here && !was_here;
      f.exit_pulse  = !here && was_here;
      was_here = here;
      due_flags.push_back(f);
    endfunction

    function void cmp_field(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest owed flags
    function void match_flags(tick_flags_t got);
      tick_flags_t want;
      if (due_flags.size() == 0) begin
        $display("%0t: result beat with nothing owed, expected none, got %b", $time, got);
        errors++;
        return;
      end
      want = due_flags.pop_front();
      checked++;
      cmp_field("present", want.present, got.present);
      cmp_field("leaving", want.leaving, got.leaving);
      cmp_field("stay_short", want.stay_short, got.stay_short);
      cmp_field("stay_long", want.stay_long, got.stay_long);
      cmp_field("absent_held", want.absent_held, got.absent_held);
      cmp_field("enter_pulse", want.enter_pulse, got.enter_pulse);
      cmp_field("exit_pulse", want.exit_pulse, got.exit_pulse);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  psq_pkg::cfg_idx_t cfg_index = '0;
  psq_pkg::cnt_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic sensor_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic present, leaving, stay_short, stay_long, absent_held, enter_pulse, exit_pulse;

  presence_tracker board = new();
  bit sender_gaps_on = 1'b0;
  bit drain_gaps_on = 1'b0;
  int hold_off_cycles = 0;
  int samples_sent = 0;
  int settings_used = 0;

  presence_sensor_qualifier dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sensor_level(sensor_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .present(present),
    .leaving(leaving),
    .stay_short(stay_short),
    .stay_long(stay_long),
    .absent_held(absent_held),
    .enter_pulse(enter_pulse),
    .exit_pulse(exit_pulse)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin : result_side
    int stall;
    tick_flags_t got;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = {present, leaving, stay_short, stay_long, absent_held,
               enter_pulse, exit_pulse};
        board.match_flags(got);
        stall = drain_gaps_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One sample beat; valid stays up afterwards until the next call or a drain
  task automatic send_sample(input logic level);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_sample(level);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input psq_pkg::cfg_idx_t idx, input psq_pkg::cnt_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(input psq_pkg::cnt_t trig, input psq_pkg::cnt_t err,
                               input psq_pkg::cnt_t ent, input psq_pkg::cnt_t ext,
                               input psq_pkg::cnt_t shrt, input psq_pkg::cnt_t lng,
                               input psq_pkg::cnt_t hold);
    wait_drained();
    write_reg(psq_pkg::REG_TRIGGER, trig);
    write_reg(psq_pkg::REG_ERROR, err);
    write_reg(psq_pkg::REG_ENTER_WIN, ent);
    write_reg(psq_pkg::REG_EXIT_WIN, ext);
    write_reg(psq_pkg::REG_STAY_SHORT, shrt);
    write_reg(psq_pkg::REG_STAY_LONG, lng);
    write_reg(psq_pkg::REG_ABSENT, hold);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic psq_pkg::cnt_t pick(input int lo, input int hi);
    return psq_pkg::cnt_t'($urandom_range(hi, lo));
  endfunction

  // Steady runs of one level with random length, odd single-tick glitches
  task automatic drive_runs(input int n_items, input int span);
    logic level;
    int run_len;
    int sent;
    level = 1'($urandom_range(0, 1));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_sample(!level);
        sent++;
      end else begin
        run_len = $urandom_range(span, 1);
        while (run_len > 0 && sent < n_items) begin
          send_sample(level);
          sent++;
          run_len--;
        end
        if ($urandom_range(0, 5) != 0) level = !level;
      end
    end
  endtask

  initial begin : main_flow
    logic [15:0] pattern;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a few ticks at reset values, then every limit set to one
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    apply_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    pattern = 16'b1100_1010_1111_0000;
    for (int i = 0; i < 16; i++) send_sample(pattern[i]);

    // Small limits, idling on both sides
    sender_gaps_on = 1'b1;
    drain_gaps_on = 1'b1;
    apply_setting(pick(1, 6), pick(1, 4), pick(1, 12), pick(1, 12),
                  pick(1, 10), pick(1, 30), pick(1, 10));
    drive_runs(150, 12);

    // Long limit at or under the short one, full rate
    sender_gaps_on = 1'b0;
    drain_gaps_on = 1'b0;
    apply_setting(pick(1, 5), pick(1, 4), pick(1, 10), pick(1, 10),
                  pick(5, 20), pick(1, 5), pick(1, 8));
    drive_runs(100, 10);

    // All limits zero, plus a write to the unused index
    sender_gaps_on = 1'b1;
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(psq_pkg::cfg_idx_t'(7), pick(0, 65535));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    drive_runs(60, 4);

    // All limits at the top
    drain_gaps_on = 1'b1;
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_runs(40, 20);

    // Back pressure: receiver holds off while samples keep coming, then
    // the sender waits for the block to empty before going on
    sender_gaps_on = 1'b0;
    drain_gaps_on = 1'b0;
    apply_setting(pick(1, 5), pick(1, 4), pick(1, 10), pick(1, 10),
                  pick(1, 8), pick(1, 25), pick(1, 8));
    hold_off_cycles = 300;
    drive_runs(80, 10);
    wait_drained();
    drive_runs(70, 10);

    // Moderate limits, idling on both sides
    sender_gaps_on = 1'b1;
    drain_gaps_on = 1'b1;
    apply_setting(pick(1, 12), pick(1, 8), pick(1, 40), pick(1, 40),
                  pick(1, 40), pick(1, 120), pick(1, 40));
    drive_runs(200, 30);

    // Wider spread, sender only idles
    drain_gaps_on = 1'b0;
    apply_setting(pick(1, 20), pick(1, 10), pick(1, 60), pick(1, 60),
                  pick(1, 30), pick(1, 60), pick(1, 30));
    drive_runs(100, 40);

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d sensor samples over %0d register settings; %0d result beats checked.",
             samples_sent, settings_used, board.checked);
    if (board.pending() != 0)
      $display("%0t: %0d results never arrived", $time, board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== presence_sensor_qualifier.f =====
sv/psq_pkg.sv
sv/presence_sensor_qualifier.sv
bench/testbench.sv
